@@ sv/qsed_pkg.sv @@
// Package for the quoted string escape decoder.
// Holds the shared job, phase and result kind types and the queue depth default.
// No dependencies.
`timescale 1ns / 1ps

package qsed_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int JOB_BYTES = 4;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_QUOTE = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_TEXT = 2'd0,
      PH_ESC  = 2'd1,
      PH_HEX  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                nbytes;
      logic                      has_end;
      kind_type                  end_kind;
   } job_type;

endpackage

@@ sv/qsed_front.sv @@
// Front end of the quoted string escape decoder: tracks the escape phase,
// gathers hex digits and turns accepted bytes into jobs of result bytes.
// Depends on qsed_pkg.
`timescale 1ns / 1ps

module qsed_front import qsed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       no_more_input,
   output logic       push,
   output job_type    push_job
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  digits_ff, digits_in;
   logic [31:0] cp_ff, cp_in;

   function automatic job_type utf8_encode(input logic [31:0] cp);
      job_type j;
      j = '0;
      if (cp < 32'h80) begin
         j.bytes[0] = cp[7:0];
         j.nbytes   = 3'd1;
      end else if (cp < 32'h800) begin
         j.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
         j.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
         j.nbytes   = 3'd2;
      end else if (cp < 32'h10000) begin
         j.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
         j.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
         j.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
         j.nbytes   = 3'd3;
      end else if (cp <= 32'h10FFFF) begin
         j.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
         j.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
         j.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
         j.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
         j.nbytes   = 3'd4;
      end
      return j;
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= "0" && c <= "9") begin
         v = 4'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         v = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         v = 4'(c - "A" + 8'd10);
      end
      return v;
   endfunction

   function automatic logic [7:0] escape_char(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         "n":     r = 8'h0A;
         "t":     r = 8'h09;
         "r":     r = 8'h0D;
         "a":     r = 8'h07;
         "b":     r = 8'h08;
         "e":     r = 8'h1B;
         "v":     r = 8'h0B;
         "0":     r = 8'h00;
         default: r = c;
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TEXT;
         digits_ff <= 4'd0;
         cp_ff     <= 32'd0;
      end else begin
         phase_ff  <= phase_in;
         digits_ff <= digits_in;
         cp_ff     <= cp_in;
      end
   end

   always_comb begin
      logic [31:0] cp_shift;
      job_type     enc;
      cp_shift  = {cp_ff[27:0], hex_value(data_byte)};
      enc       = '0;
      phase_in  = phase_ff;
      digits_in = digits_ff;
      cp_in     = cp_ff;
      push      = 1'b0;
      push_job  = '0;
      if (accept) begin
         if (no_more_input) begin
            if (phase_ff == PH_HEX) begin
               enc = utf8_encode(cp_ff);
            end
            push_job          = enc;
            push_job.has_end  = 1'b1;
            push_job.end_kind = KIND_END;
            push              = 1'b1;
            phase_in          = PH_TEXT;
            digits_in         = 4'd0;
            cp_in             = 32'd0;
         end else begin
            case (phase_ff)
               PH_ESC: begin
                  phase_in = PH_TEXT;
                  if (data_byte == "x" || data_byte == "u" || data_byte == "U") begin
                     phase_in  = PH_HEX;
                     digits_in = (data_byte == "x") ? 4'd2 :
                                 ((data_byte == "u") ? 4'd4 : 4'd8);
                     cp_in     = 32'd0;
                  end else if (data_byte == "N" || data_byte == "_") begin
                     push_job.bytes[0] = 8'hC2;
                     push_job.bytes[1] = (data_byte == "N") ? 8'h85 : 8'hA0;
                     push_job.nbytes   = 3'd2;
                     push              = 1'b1;
                  end else begin
                     push_job.bytes[0] = escape_char(data_byte);
                     push_job.nbytes   = 3'd1;
                     push              = 1'b1;
                  end
               end
               PH_HEX: begin
                  digits_in = digits_ff - 4'd1;
                  if (digits_ff == 4'd1) begin
                     enc      = utf8_encode(cp_shift);
                     push_job = enc;
                     push     = (enc.nbytes != 3'd0);
                     phase_in = PH_TEXT;
                     cp_in    = 32'd0;
                  end else begin
                     cp_in = cp_shift;
                  end
               end
               default: begin
                  if (data_byte == 8'h22) begin
                     push_job.has_end  = 1'b1;
                     push_job.end_kind = KIND_QUOTE;
                     push              = 1'b1;
                     phase_in          = PH_TEXT;
                     digits_in         = 4'd0;
                     cp_in             = 32'd0;
                  end else if (data_byte == 8'h5C) begin
                     phase_in = PH_ESC;
                  end else begin
                     push_job.bytes[0] = data_byte;
                     push_job.nbytes   = 3'd1;
                     push              = 1'b1;
                  end
               end
            endcase
         end
      end
   end

endmodule

@@ sv/qsed_queue.sv @@
// Short job queue between the front end and the back end of the decoder.
// Depends on qsed_pkg.
`timescale 1ns / 1ps

module qsed_queue import qsed_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    not_full,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign not_full   = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && not_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ sv/qsed_back.sv @@
// Back end of the decoder: walks the job at the queue head one result per
// cycle into the output register when not stalled. Depends on qsed_pkg.
`timescale 1ns / 1ps

module qsed_back import qsed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_user_ff, rsp_user_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [2:0] pos_ff, pos_in;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      logic [2:0] total;
      logic       advance;
      logic       is_last;
      total        = head_job.nbytes + {2'b00, head_job.has_end};
      advance      = !rsp_valid_ff || rsp_tready;
      is_last      = (pos_ff == total - 3'd1);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      pos_in       = pos_ff;
      pop          = 1'b0;
      if (advance) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (pos_ff < head_job.nbytes) begin
               rsp_data_in = head_job.bytes[pos_ff[1:0]];
               rsp_user_in = KIND_BYTE;
            end else begin
               rsp_data_in = 8'd0;
               rsp_user_in = head_job.end_kind;
            end
            rsp_last_in = is_last;
            if (is_last) begin
               pos_in = 3'd0;
               pop    = 1'b1;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

@@ sv/quoted_string_escape_decoder.sv @@
// Quoted string escape decoder, top level. The first result of an accepted
// byte passes through the job queue and then the output register. Throughput:
// one byte per cycle while each byte yields at most one result and the output
// is not stalled; the job queue of QUEUE_DEPTH entries absorbs bursts of bytes
// whose several results hold the back end. Reset is synchronous and returns
// the decoder to the text phase with the queue and output register empty.
`timescale 1ns / 1ps

module quoted_string_escape_decoder import qsed_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // data_byte
   input  logic       req_tlast,  // no_more_input
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // out_byte
   output logic [1:0] rsp_tuser,  // result_kind
   output logic       rsp_tlast   // last_of_run
);

   logic    accept;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    not_full;
   logic    head_valid;
   job_type head_job;

   assign req_tready = not_full;
   assign accept     = req_tvalid && req_tready;

   qsed_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .no_more_input (req_tlast),
      .push          (push),
      .push_job      (push_job)
   );

   qsed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .not_full   (not_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   qsed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_BYTE) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("End result without last flag or with nonzero byte.");

   a_full_means_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> rsp_tvalid)
      else $error("Queue full but no result presented.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("Queue popped while empty.");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the quoted string escape decoder.
// Predicts decoded bytes and string ends per accepted input transfer and checks
// every result transfer in order. Depends on qsed_pkg and quoted_string_escape_decoder.
`timescale 1ns / 1ps

module testbench import qsed_pkg::*;;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DIRECTED_ITEMS = 24;
   localparam int RANDOM_ITEMS = 306;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       last;
   } decoded_type;

   class escape_scoreboard;
      phase_type   phase;
      logic [3:0]  digits_left;
      logic [31:0] code_point;
      decoded_type expected_out[$];
      decoded_type burst[$];
      int          mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         phase = PH_TEXT;
         digits_left = 4'd0;
         code_point = 32'd0;
      endfunction

      function void add(logic [7:0] b, kind_type k);
         decoded_type r;
         r.data = b;
         r.kind = k;
         r.last = 1'b0;
         burst.push_back(r);
      endfunction

      function void add_utf8(logic [31:0] cp);
         if (cp < 32'h80) begin
            add(cp[7:0], KIND_BYTE);
         end else if (cp < 32'h800) begin
            add({3'b110, cp[10:6]}, KIND_BYTE);
            add({2'b10, cp[5:0]}, KIND_BYTE);
         end else if (cp < 32'h10000) begin
            add({4'b1110, cp[15:12]}, KIND_BYTE);
            add({2'b10, cp[11:6]}, KIND_BYTE);
            add({2'b10, cp[5:0]}, KIND_BYTE);
         end else if (cp <= 32'h10FFFF) begin
            add({5'b11110, cp[20:18]}, KIND_BYTE);
            add({2'b10, cp[17:12]}, KIND_BYTE);
            add({2'b10, cp[11:6]}, KIND_BYTE);
            add({2'b10, cp[5:0]}, KIND_BYTE);
         end
      endfunction

      function logic [3:0] hex_digit(logic [7:0] c);
         logic [7:0] v;
         v = 8'd0;
         if (c >= "0" && c <= "9") v = c - "0";
         else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
         else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
         return v[3:0];
      endfunction

      function void note_byte(logic [7:0] c, logic done);
         decoded_type r;
         burst.delete();
         if (done) begin
            if (phase == PH_HEX) add_utf8(code_point);
            add(8'h00, KIND_END);
            restart();
         end else begin
            case (phase)
               PH_ESC: begin
                  phase = PH_TEXT;
                  case (c)
                     "n": add(8'h0A, KIND_BYTE);
                     "t": add(8'h09, KIND_BYTE);
                     "r": add(8'h0D, KIND_BYTE);
                     "a": add(8'h07, KIND_BYTE);
                     "b": add(8'h08, KIND_BYTE);
                     "e": add(8'h1B, KIND_BYTE);
                     "v": add(8'h0B, KIND_BYTE);
                     "0": add(8'h00, KIND_BYTE);
                     "N": begin
                        add(8'hC2, KIND_BYTE);
                        add(8'h85, KIND_BYTE);
                     end
                     "_": begin
                        add(8'hC2, KIND_BYTE);
                        add(8'hA0, KIND_BYTE);
                     end
                     "x", "u", "U": begin
                        phase = PH_HEX;
                        digits_left = (c == "x") ? 4'd2 : ((c == "u") ? 4'd4 : 4'd8);
                        code_point = 32'd0;
                     end
                     default: add(c, KIND_BYTE);
                  endcase
               end
               PH_HEX: begin
                  code_point = {code_point[27:0], hex_digit(c)};
                  digits_left = digits_left - 4'd1;
                  if (digits_left == 4'd0) begin
                     add_utf8(code_point);
                     phase = PH_TEXT;
                     code_point = 32'd0;
                  end
               end
               default: begin
                  if (c == "\"") begin
                     add(8'h00, KIND_QUOTE);
                     restart();
                  end else if (c == "\\") begin
                     phase = PH_ESC;
                  end else begin
                     add(c, KIND_BYTE);
                  end
               end
            endcase
         end
         foreach (burst[i]) begin
            r = burst[i];
            r.last = (i == burst.size() - 1);
            expected_out.push_back(r);
         end
      endfunction

      function void check_output(logic [7:0] b, logic [1:0] k, logic l);
         decoded_type want;
         if (expected_out.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: data %h kind %0d last %0d", b, k, l);
            return;
         end
         want = expected_out.pop_front();
         if (want.data !== b || want.kind !== kind_type'(k) || want.last !== l) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"Mismatch: expected data %h kind %0d last %0d,",
                         " got data %h kind %0d last %0d"},
                        want.data, want.kind, want.last, b, k, l);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   escape_scoreboard board = new();
   int items_sent = 0;
   int send_idle_pct = 22;
   int recv_idle_pct = 76;
   int cycle_count = 0;

   quoted_string_escape_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_output(rsp_tdata, rsp_tuser, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(input logic [7:0] d, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      board.note_byte(d, l);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      logic [7:0] base;
      base = ($urandom_range(1) == 0) ? 8'h61 : 8'h41;
      if (nib < 4'd10) return 8'h30 + {4'd0, nib};
      return base + {4'd0, nib} - 8'd10;
   endfunction

   task automatic send_hex_escape(output bit ended);
      int width, cut, i;
      logic [31:0] value;
      logic [7:0] c;
      logic [31:0] extremes[10] = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF,
                                    32'h10000, 32'h10FFFF, 32'h110000, 32'hFFFFFFFF};
      ended = 1'b0;
      case ($urandom_range(2))
         0: begin width = 2; send_item("x", 1'b0); end
         1: begin width = 4; send_item("u", 1'b0); end
         default: begin width = 8; send_item("U", 1'b0); end
      endcase
      case ($urandom_range(5))
         0: value = $urandom_range(32'h7F);
         1: value = $urandom_range(32'h7FF, 32'h80);
         2: value = $urandom_range(32'hFFFF, 32'h800);
         3: value = $urandom_range(32'h10FFFF, 32'h10000);
         4: value = $urandom_range(32'hFFFFFFFF, 32'h110000);
         default: value = extremes[$urandom_range(9)];
      endcase
      cut = ($urandom_range(11) == 0) ? $urandom_range(width - 1) : width;
      for (i = 0; i < cut; i++) begin
         c = hex_char(value[4 * (width - 1 - i) +: 4]);
         if ($urandom_range(19) == 0) c = 8'($urandom_range(255));
         send_item(c, 1'b0);
      end
      if (cut < width) begin
         send_item(8'($urandom_range(255)), 1'b1);
         ended = 1'b1;
      end
   endtask

   task automatic send_string();
      int nseg, i;
      logic [7:0] b;
      bit ended;
      string letters;
      letters = "ntrabev0\\\"/N_";
      ended = 1'b0;
      nseg = $urandom_range(8);
      for (i = 0; i < nseg && !ended; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               b = 8'($urandom_range(255));
               if (b == "\"" || b == "\\") b = 8'h0A;
               send_item(b, 1'b0);
            end
            4, 5: begin
               send_item("\\", 1'b0);
               if ($urandom_range(3) == 0) b = 8'($urandom_range(255));
               else b = letters[$urandom_range(letters.len() - 1)];
               send_item(b, 1'b0);
            end
            default: send_hex_escape(ended);
         endcase
      end
      if (!ended) begin
         case ($urandom_range(7))
            0: send_item(8'($urandom_range(255)), 1'b1);
            1: begin
               send_item("\\", 1'b0);
               send_item(8'($urandom_range(255)), 1'b1);
            end
            default: send_item("\"", 1'b0);
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("\\N");
      send_text("\\z");
      send_text("\\U00110000");
      send_item("\"", 1'b0);
      send_text("\\xg");
      send_item(8'hFF, 1'b1);
      send_text("\\");
      send_item(8'h5A, 1'b1);
      send_item(8'hFF, 1'b1);

      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         if (items_sent >= DIRECTED_ITEMS + 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (items_sent >= DIRECTED_ITEMS + RANDOM_ITEMS / 3) begin
            send_idle_pct = 76;
            recv_idle_pct = 22;
         end
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(4, 1))
               send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
         else
            send_string();
      end
      req_tvalid <= 1'b0;

      while (board.expected_out.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (board.mismatches == 0 && board.expected_out.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ quoted_string_escape_decoder.f @@
sv/qsed_pkg.sv
sv/qsed_front.sv
sv/qsed_queue.sv
sv/qsed_back.sv
sv/quoted_string_escape_decoder.sv
tb/testbench.sv
